// ===== hw/rtl/seasonal_climate_mode_selector_macros.svh =====
// assertion macros shared by the rtl
`ifndef SEASONAL_CLIMATE_MODE_SELECTOR_MACROS_SVH
`define SEASONAL_CLIMATE_MODE_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scms assertion failed");

// next-cycle implication
`define SCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scms assertion failed");

`else

`define SCMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/scms_pkg.sv =====
`default_nettype none

package scms_pkg;

	localparam int TempW     = 11;
	localparam int BandW     = 7;
	localparam int HumW      = 10;
	localparam int ColdW     = 10;
	localparam int MonthW    = 4;
	localparam int HourW     = 5;
	localparam int ModeW     = 3;
	localparam int ApbAddrW  = 5;
	localparam int ApbDataW  = 32;
	localparam int RegIdxW   = 3;

	// threshold math is one bit wider than a temperature
	localparam int ThrW = TempW + 1;

	localparam logic [TempW-1:0] TempLowReset  = 11'd242;
	localparam logic [TempW-1:0] TempHighReset = 11'd265;
	localparam logic [BandW-1:0] BandReset     = 7'd3;
	localparam logic [HumW-1:0]  HumReset      = 10'd620;
	localparam logic [ColdW-1:0] ColdReset     = 10'd0;

	localparam logic [HourW-1:0] NightEndHour   = 5'd7;
	localparam logic [HourW-1:0] NightStartHour = 5'd23;

	// register indexes, byte address is 4 times the index
	localparam logic [RegIdxW-1:0] REG_TEMP_LOW  = 3'd0;
	localparam logic [RegIdxW-1:0] REG_TEMP_HIGH = 3'd1;
	localparam logic [RegIdxW-1:0] REG_BAND      = 3'd2;
	localparam logic [RegIdxW-1:0] REG_HUM_HIGH  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_COLD_DAY  = 3'd4;

	typedef enum logic [ModeW-1:0] {
		MODE_NONE      = 3'd0,
		MODE_OFF       = 3'd1,
		MODE_HEAT_HIGH = 3'd2,
		MODE_HEAT_LOW  = 3'd3,
		MODE_COOL      = 3'd4,
		MODE_DRY       = 3'd5
	} mode_t;

	typedef struct packed {
		logic [TempW-1:0] temp_low_limit;
		logic [TempW-1:0] temp_high_limit;
		logic [BandW-1:0] hysteresis_band;
		logic [HumW-1:0]  humidity_high_limit;
		logic [ColdW-1:0] cold_day_limit;
	} cfg_t;

	typedef struct packed {
		logic              time_ok;
		logic [MonthW-1:0] month;
		logic [HourW-1:0]  hour;
		logic [TempW-1:0]  room_temp;
		logic [HumW-1:0]   room_humidity;
		logic              forecast_ok;
		logic [TempW-1:0]  forecast_min_temp;
	} sample_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scms_in_if.sv =====
`default_nettype none

interface scms_in_if;
	logic                         valid;
	logic                         ready;
	logic                         time_ok;
	logic [scms_pkg::MonthW-1:0]  month;
	logic [scms_pkg::HourW-1:0]   hour;
	logic signed [scms_pkg::TempW-1:0] room_temp;
	logic [scms_pkg::HumW-1:0]    room_humidity;
	logic                         forecast_ok;
	logic signed [scms_pkg::TempW-1:0] forecast_min_temp;

	modport source (
		output valid, time_ok, month, hour, room_temp, room_humidity,
			forecast_ok, forecast_min_temp,
		input  ready
	);

	modport sink (
		input  valid, time_ok, month, hour, room_temp, room_humidity,
			forecast_ok, forecast_min_temp,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/scms_out_if.sv =====
`default_nettype none

interface scms_out_if;
	logic                       valid;
	logic                       ready;
	logic [scms_pkg::ModeW-1:0] chosen_mode;
	logic                       send_command;

	modport source (
		output valid, chosen_mode, send_command,
		input  ready
	);

	modport sink (
		input  valid, chosen_mode, send_command,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/scms_cfg.sv =====
`default_nettype none

module scms_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [scms_pkg::ApbAddrW-1:0]  paddr,
	input  wire logic [scms_pkg::ApbDataW-1:0]  pwdata,
	output logic      [scms_pkg::ApbDataW-1:0]  prdata,
	output logic                                pready,
	output scms_pkg::cfg_t                      cfg
);

	scms_pkg::cfg_t                  cfg_q;
	logic                            wr_en;
	logic [scms_pkg::RegIdxW-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[scms_pkg::ApbAddrW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low_limit      <= scms_pkg::TempLowReset;
			cfg_q.temp_high_limit     <= scms_pkg::TempHighReset;
			cfg_q.hysteresis_band     <= scms_pkg::BandReset;
			cfg_q.humidity_high_limit <= scms_pkg::HumReset;
			cfg_q.cold_day_limit      <= scms_pkg::ColdReset;
		end else if (wr_en) begin
			case (reg_idx)
				scms_pkg::REG_TEMP_LOW:  cfg_q.temp_low_limit  <= pwdata[scms_pkg::TempW-1:0];
				scms_pkg::REG_TEMP_HIGH: cfg_q.temp_high_limit <= pwdata[scms_pkg::TempW-1:0];
				scms_pkg::REG_BAND:      cfg_q.hysteresis_band <= pwdata[scms_pkg::BandW-1:0];
				scms_pkg::REG_HUM_HIGH:  cfg_q.humidity_high_limit <= pwdata[scms_pkg::HumW-1:0];
				scms_pkg::REG_COLD_DAY:  cfg_q.cold_day_limit  <= pwdata[scms_pkg::ColdW-1:0];
				default: ;
			endcase
		end
	end

	// readback, zero extended
	always_comb begin
		case (reg_idx)
			scms_pkg::REG_TEMP_LOW:  prdata = 32'(cfg_q.temp_low_limit);
			scms_pkg::REG_TEMP_HIGH: prdata = 32'(cfg_q.temp_high_limit);
			scms_pkg::REG_BAND:      prdata = 32'(cfg_q.hysteresis_band);
			scms_pkg::REG_HUM_HIGH:  prdata = 32'(cfg_q.humidity_high_limit);
			scms_pkg::REG_COLD_DAY:  prdata = 32'(cfg_q.cold_day_limit);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/scms_decide.sv =====
`default_nettype none

module scms_decide (
	input  wire scms_pkg::sample_t sample,
	input  wire scms_pkg::cfg_t    cfg,
	input  wire scms_pkg::mode_t   applied,
	output scms_pkg::mode_t        mode
);

	logic signed [scms_pkg::ThrW-1:0]  t_w;
	logic signed [scms_pkg::ThrW-1:0]  lo_w;
	logic signed [scms_pkg::ThrW-1:0]  hi_w;
	logic signed [scms_pkg::ThrW-1:0]  band_w;
	logic signed [scms_pkg::ThrW-1:0]  heat_off;
	logic signed [scms_pkg::ThrW-1:0]  cool_off;
	logic signed [scms_pkg::TempW-1:0] fmin_w;
	logic signed [scms_pkg::TempW-1:0] cold_w;
	logic                              summer;
	logic                              mild;
	logic                              night;
	logic                              cold_night;
	logic                              humid;

	assign t_w    = $signed({sample.room_temp[scms_pkg::TempW-1], sample.room_temp});
	assign lo_w   = $signed({cfg.temp_low_limit[scms_pkg::TempW-1], cfg.temp_low_limit});
	assign hi_w   = $signed({cfg.temp_high_limit[scms_pkg::TempW-1], cfg.temp_high_limit});
	assign band_w = $signed({{(scms_pkg::ThrW-scms_pkg::BandW){1'b0}}, cfg.hysteresis_band});
	assign heat_off = lo_w + band_w;
	assign cool_off = hi_w - band_w;

	assign fmin_w = $signed(sample.forecast_min_temp);
	assign cold_w = $signed({cfg.cold_day_limit[scms_pkg::ColdW-1], cfg.cold_day_limit});

	assign humid = sample.room_humidity > cfg.humidity_high_limit;

	always_comb begin
		summer = sample.month inside {[4'd6:4'd9]};
		mild   = sample.month inside {[4'd3:4'd5], [4'd10:4'd11]};
		night  = (sample.hour < scms_pkg::NightEndHour) ||
			(sample.hour >= scms_pkg::NightStartHour);
		cold_night = night && sample.forecast_ok && (fmin_w <= cold_w);
	end

	always_comb begin
		mode = scms_pkg::MODE_OFF;
		if (!sample.time_ok) begin
			mode = scms_pkg::MODE_OFF;
		end else if (summer) begin
			if (t_w < lo_w)
				mode = scms_pkg::MODE_OFF;
			else if (applied == scms_pkg::MODE_COOL && t_w > cool_off)
				mode = scms_pkg::MODE_COOL;
			else if (applied == scms_pkg::MODE_DRY && t_w > cool_off && humid)
				mode = scms_pkg::MODE_DRY;
			else if (t_w > hi_w)
				mode = scms_pkg::MODE_COOL;
			else if (humid)
				mode = scms_pkg::MODE_DRY;
			else
				mode = scms_pkg::MODE_OFF;
		end else if (mild) begin
			if (night)
				mode = scms_pkg::MODE_OFF;
			else if (t_w < lo_w)
				mode = scms_pkg::MODE_HEAT_HIGH;
			else if (applied == scms_pkg::MODE_HEAT_HIGH && t_w < heat_off)
				mode = scms_pkg::MODE_HEAT_HIGH;
			else if (t_w > hi_w)
				mode = scms_pkg::MODE_COOL;
			else if (applied == scms_pkg::MODE_COOL && t_w > cool_off)
				mode = scms_pkg::MODE_COOL;
			else
				mode = scms_pkg::MODE_OFF;
		end else if (cold_night) begin
			mode = scms_pkg::MODE_HEAT_LOW;
		end else if (night) begin
			mode = scms_pkg::MODE_OFF;
		end else if (t_w < lo_w ||
			(applied == scms_pkg::MODE_HEAT_HIGH && t_w < heat_off)) begin
			mode = scms_pkg::MODE_HEAT_HIGH;
		end else begin
			mode = scms_pkg::MODE_OFF;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/seasonal_climate_mode_selector.sv =====
`default_nettype none
`include "seasonal_climate_mode_selector_macros.svh"

// Seasonal climate mode selector. Each sample beat (time flag, month, hour,
// room temperature and humidity in tenths, forecast minimum with its valid
// flag) yields exactly one result beat: the chosen air-conditioner mode
// (1 off, 2 heat 23.5, 3 heat 18, 4 cool 25, 5 dry) and send_command, which is
// high when that mode differs from the mode applied by the previous sample.
// The first result after reset always sends. The block is a two-register
// pipe: the sample register, then the rule logic and the result register,
// with the applied mode updated on the same edge that loads the result.
// It takes one sample per clock, sustained; a sample passes the sample register
// and then the result register; only backpressure on the result side slows it.
// Thresholds live in five APB registers at byte addresses 0, 4, 8, 12, 16
// (low limit, high limit, hysteresis band, humidity limit, cold-night limit)
// and should only be written while no sample is in flight.
module seasonal_climate_mode_selector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	scms_in_if.sink                             sample,
	scms_out_if.source                          result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [scms_pkg::ApbAddrW-1:0]  paddr,
	input  wire logic [scms_pkg::ApbDataW-1:0]  pwdata,
	output logic      [scms_pkg::ApbDataW-1:0]  prdata,
	output logic                                pready
);

	scms_pkg::cfg_t    cfg;

	// sample register
	scms_pkg::sample_t sample_s1;
	logic              valid_s1;

	// result register
	scms_pkg::mode_t   mode_s2;
	logic              send_s2;
	logic              valid_s2;

	// last mode handed out, none after reset
	scms_pkg::mode_t   applied_mode_q;

	scms_pkg::mode_t   mode_next;
	logic              take_in;
	logic              adv_s2;

	scms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result stage moves when empty or being drained
	assign adv_s2       = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv_s2;
	assign take_in      = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1.time_ok           <= sample.time_ok;
			sample_s1.month             <= sample.month;
			sample_s1.hour              <= sample.hour;
			sample_s1.room_temp         <= sample.room_temp;
			sample_s1.room_humidity     <= sample.room_humidity;
			sample_s1.forecast_ok       <= sample.forecast_ok;
			sample_s1.forecast_min_temp <= sample.forecast_min_temp;
		end
	end

	// season, night and hysteresis rules against the applied mode
	scms_decide u_decide (
		.sample  (sample_s1),
		.cfg     (cfg),
		.applied (applied_mode_q),
		.mode    (mode_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			applied_mode_q <= scms_pkg::MODE_NONE;
		end else begin
			if (adv_s2) begin
				valid_s2       <= 1'b1;
				applied_mode_q <= mode_next;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mode_s2 <= mode_next;
			send_s2 <= (mode_next != applied_mode_q);
		end
	end

	assign result.valid        = valid_s2;
	assign result.chosen_mode  = mode_s2;
	assign result.send_command = send_s2;

	// the applied mode always matches the result just loaded
	`SCMS_ASSERT_NEXT(a_applied_tracks_result, clk, arst_n, adv_s2, applied_mode_q == mode_s2)

	// a send beat means the applied mode really changed
	`SCMS_ASSERT_NEXT(a_send_on_change, clk, arst_n, adv_s2, send_s2 == (applied_mode_q != $past(applied_mode_q)))

	// once a result exists, some mode is applied
	`SCMS_ASSERT_IMPL(a_mode_applied, clk, arst_n, valid_s2, applied_mode_q != scms_pkg::MODE_NONE)

endmodule

`default_nettype wire

// ===== tb/tb_seasonal_climate_mode_selector.sv =====
`timescale 1ns / 100ps

module tb_seasonal_climate_mode_selector;
	import scms_pkg::*;

	// run limit, far above the slowest legal run
	localparam int CycleLimit = 400000;
	// length of the long result-side hold-off
	localparam int HoldCycles = 80;
	localparam int RandPhases = 8;
	localparam int PhaseBeats = 125;

	typedef struct {
		mode_t mode;
		logic  send;
	} mode_beat_t;

	typedef struct {
		sample_t    smp;
		logic       typed;
		mode_beat_t beat;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic pready;

	scms_in_if  sample_ch ();
	scms_out_if result_ch ();

	seasonal_climate_mode_selector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// local copy of the block: thresholds as written and the mode in force
	cfg_t  cfg_now;
	mode_t mode_in_force;

	// results still owed by the block, oldest first
	mode_beat_t pending_modes[$];

	// a directed row may carry its result typed in; held with the beat
	logic       typed_now;
	mode_beat_t typed_beat;

	// idling on both sides, and a request for the long result hold-off
	logic idle_on;
	logic hold_long;

	int errors;
	int cycles;
	logic [MonthW-1:0] cur_month;

	directed_row_t steps[$];

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	// mode selection rules on the sign-extended integers
	function automatic mode_t pick_mode(sample_t s);
		int t, h, fmin, lo, hi, band, hum, cold, hoff, coff;
		logic night;
		mode_t m;
		t    = int'($signed(s.room_temp));
		h    = int'(s.room_humidity);
		fmin = int'($signed(s.forecast_min_temp));
		lo   = int'($signed(cfg_now.temp_low_limit));
		hi   = int'($signed(cfg_now.temp_high_limit));
		band = int'(cfg_now.hysteresis_band);
		hum  = int'(cfg_now.humidity_high_limit);
		cold = int'($signed(cfg_now.cold_day_limit));
		hoff = lo + band;
		coff = hi - band;
		// out-of-range hours land in the night
		night = (s.hour < NightEndHour) || (s.hour >= NightStartHour);
		if (!s.time_ok) begin
			m = MODE_OFF;
		end else if (s.month >= 6 && s.month <= 9) begin
			// summer: no heating, cool or dry with hysteresis, day and night alike
			if (t < lo)
				m = MODE_OFF;
			else if (mode_in_force == MODE_COOL && t > coff)
				m = MODE_COOL;
			else if (mode_in_force == MODE_DRY && t > coff && h > hum)
				m = MODE_DRY;
			else if (t > hi)
				m = MODE_COOL;
			else if (h > hum)
				m = MODE_DRY;
			else
				m = MODE_OFF;
		end else if ((s.month >= 3 && s.month <= 5) || (s.month >= 10 && s.month <= 11)) begin
			// spring and autumn: off at night, heat or cool by day
			if (night)
				m = MODE_OFF;
			else if (t < lo)
				m = MODE_HEAT_HIGH;
			else if (mode_in_force == MODE_HEAT_HIGH && t < hoff)
				m = MODE_HEAT_HIGH;
			else if (t > hi)
				m = MODE_COOL;
			else if (mode_in_force == MODE_COOL && t > coff)
				m = MODE_COOL;
			else
				m = MODE_OFF;
		end else if (night && s.forecast_ok && fmin <= cold) begin
			// winter, including months 0 and 13-15: cold night heats low
			m = MODE_HEAT_LOW;
		end else if (night) begin
			m = MODE_OFF;
		end else if (t < lo || (mode_in_force == MODE_HEAT_HIGH && t < hoff)) begin
			m = MODE_HEAT_HIGH;
		end else begin
			m = MODE_OFF;
		end
		return m;
	endfunction

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic directed_row_t mk_row(int tok, int month, int hour, int temp, int hum,
			int fok, int fmin, int typed, mode_t m, int snd);
		directed_row_t row;
		row.smp.time_ok           = tok[0];
		row.smp.month             = month[MonthW-1:0];
		row.smp.hour              = hour[HourW-1:0];
		row.smp.room_temp         = temp[TempW-1:0];
		row.smp.room_humidity     = hum[HumW-1:0];
		row.smp.forecast_ok       = fok[0];
		row.smp.forecast_min_temp = fmin[TempW-1:0];
		row.typed                 = typed[0];
		row.beat.mode             = m;
		row.beat.send             = snd[0];
		return row;
	endfunction

	// random sample: mostly near the live thresholds so hysteresis gets exercised,
	// the rest spread over the stated ranges or over every raw bit pattern
	function automatic sample_t random_sample();
		sample_t s;
		int lo, hi, band, hum, cold, ctr, t, h, f, r;
		lo   = int'($signed(cfg_now.temp_low_limit));
		hi   = int'($signed(cfg_now.temp_high_limit));
		band = int'(cfg_now.hysteresis_band);
		hum  = int'(cfg_now.humidity_high_limit);
		cold = int'($signed(cfg_now.cold_day_limit));
		// the season sticks for a while so the mode in force carries over
		if ($urandom_range(0, 99) < 12)
			cur_month = MonthW'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
				: $urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: ctr = lo;
				1: ctr = lo + band;
				2: ctr = hi;
				default: ctr = hi - band;
			endcase
			t = ctr + int'($urandom_range(0, 10)) - 5;
		end else if (r < 90) begin
			t = int'($urandom_range(0, 1250)) - 400;
		end else begin
			t = $urandom;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			h = hum + int'($urandom_range(0, 10)) - 5;
		else if (r < 85)
			h = $urandom_range(0, 1000);
		else
			h = $urandom;
		r = $urandom_range(0, 99);
		if (r < 50)
			f = cold + int'($urandom_range(0, 6)) - 3;
		else if (r < 85)
			f = int'($urandom_range(0, 1000)) - 400;
		else
			f = $urandom;
		s.time_ok           = ($urandom_range(0, 99) < 92);
		s.month             = cur_month;
		s.hour              = HourW'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 23)
			: $urandom_range(0, 31));
		s.room_temp         = t[TempW-1:0];
		s.room_humidity     = h[HumW-1:0];
		s.forecast_ok       = ($urandom_range(0, 99) < 70);
		s.forecast_min_temp = f[TempW-1:0];
		return s;
	endfunction

	// two-phase register write, model copy follows once the access completes
	task automatic write_reg(logic [RegIdxW-1:0] idx, logic [ApbDataW-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TEMP_LOW:  cfg_now.temp_low_limit      = val[TempW-1:0];
			REG_TEMP_HIGH: cfg_now.temp_high_limit     = val[TempW-1:0];
			REG_BAND:      cfg_now.hysteresis_band     = val[BandW-1:0];
			REG_HUM_HIGH:  cfg_now.humidity_high_limit = val[HumW-1:0];
			REG_COLD_DAY:  cfg_now.cold_day_limit      = val[ColdW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int lo, int hi, int band, int hum, int cold);
		write_reg(REG_TEMP_LOW,  ApbDataW'(lo)   & ((1 << TempW) - 1));
		write_reg(REG_TEMP_HIGH, ApbDataW'(hi)   & ((1 << TempW) - 1));
		write_reg(REG_BAND,      ApbDataW'(band) & ((1 << BandW) - 1));
		write_reg(REG_HUM_HIGH,  ApbDataW'(hum)  & ((1 << HumW) - 1));
		write_reg(REG_COLD_DAY,  ApbDataW'(cold) & ((1 << ColdW) - 1));
	endtask

	// offer one sample beat, hold it until taken, then maybe leave a gap
	task automatic offer_sample(sample_t s, logic typed, mode_beat_t beat);
		int n;
		@(negedge clk);
		sample_ch.valid             <= 1'b1;
		sample_ch.time_ok           <= s.time_ok;
		sample_ch.month             <= s.month;
		sample_ch.hour              <= s.hour;
		sample_ch.room_temp         <= s.room_temp;
		sample_ch.room_humidity     <= s.room_humidity;
		sample_ch.forecast_ok       <= s.forecast_ok;
		sample_ch.forecast_min_temp <= s.forecast_min_temp;
		typed_now                   <= typed;
		typed_beat                  <= beat;
		do @(posedge clk); while (!sample_ch.ready);
		if (idle_on && $urandom_range(0, 99) < 35) begin
			n = pick_gap();
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop offering and let every owed result come back, plus the pipe depth
	task automatic wait_all_results();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_modes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls, or one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				result_ch.ready <= 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
				hold_long = 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 30) begin
				n = pick_gap();
				result_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// beat monitor: check result beats, predict on sample beats
	always @(posedge clk) begin
		sample_t s;
		mode_t m;
		mode_beat_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_modes.size() == 0) begin
					report_mismatch("result beat with nothing owed, mode",
						int'(result_ch.chosen_mode), 0);
				end else begin
					want = pending_modes.pop_front();
					if (result_ch.chosen_mode !== want.mode)
						report_mismatch("chosen_mode", int'(result_ch.chosen_mode), int'(want.mode));
					if (result_ch.send_command !== want.send)
						report_mismatch("send_command", int'(result_ch.send_command), int'(want.send));
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				s.time_ok           = sample_ch.time_ok;
				s.month             = sample_ch.month;
				s.hour              = sample_ch.hour;
				s.room_temp         = sample_ch.room_temp;
				s.room_humidity     = sample_ch.room_humidity;
				s.forecast_ok       = sample_ch.forecast_ok;
				s.forecast_min_temp = sample_ch.forecast_min_temp;
				m = pick_mode(s);
				if (typed_now) begin
					pending_modes.push_back(typed_beat);
				end else begin
					want.mode = m;
					want.send = (m != mode_in_force);
					pending_modes.push_back(want);
				end
				// the chosen mode is applied after every sample
				mode_in_force = m;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		mode_beat_t no_beat;
		int lo, hi;
		no_beat.mode = MODE_NONE;
		no_beat.send = 1'b0;
		errors    = 0;
		cycles    = 0;
		idle_on   = 1'b1;
		hold_long = 1'b0;
		typed_now = 1'b0;
		typed_beat = no_beat;
		cur_month = 4'd1;
		cfg_now = '{temp_low_limit: TempLowReset, temp_high_limit: TempHighReset,
			hysteresis_band: BandReset, humidity_high_limit: HumReset,
			cold_day_limit: ColdReset};
		mode_in_force = MODE_NONE;

		// every input known from time zero
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		sample_ch.valid             = 1'b0;
		sample_ch.time_ok           = 1'b0;
		sample_ch.month             = '0;
		sample_ch.hour              = '0;
		sample_ch.room_temp         = '0;
		sample_ch.room_humidity     = '0;
		sample_ch.forecast_ok       = 1'b0;
		sample_ch.forecast_min_temp = '0;
		result_ch.ready             = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows against reset thresholds: low 24.2, high 26.5, band 0.3,
		// humidity 62.0, cold night at or below 0.0
		// first beat after reset always sends; time not valid gives off
		steps.push_back(mk_row(0, 1, 12, 0, 0, 0, 0, 1, MODE_OFF, 1));
		steps.push_back(mk_row(0, 12, 30, 850, 1000, 1, -400, 1, MODE_OFF, 0));
		// winter day at the coldest room temperature
		steps.push_back(mk_row(1, 1, 12, -400, 500, 0, 0, 1, MODE_HEAT_HIGH, 1));
		// held inside the heating band, then released at its edge
		steps.push_back(mk_row(1, 2, 12, 243, 500, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 2, 12, 245, 500, 0, 0, 0, MODE_NONE, 0));
		// cold winter night heats low
		steps.push_back(mk_row(1, 12, 2, 200, 500, 1, -400, 1, MODE_HEAT_LOW, 1));
		// forecast not valid is never a cold night
		steps.push_back(mk_row(1, 12, 2, 200, 500, 0, -400, 0, MODE_NONE, 0));
		// forecast right at the limit, then one tenth above it
		steps.push_back(mk_row(1, 1, 23, 200, 500, 1, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 1, 6, 200, 500, 1, 1, 0, MODE_NONE, 0));
		// month out of range is winter, hour out of range is night
		steps.push_back(mk_row(1, 0, 12, 100, 500, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 15, 31, 100, 500, 1, -1, 0, MODE_NONE, 0));
		// spring cooling at the hottest room, held in band, released
		steps.push_back(mk_row(1, 3, 7, 850, 500, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 5, 22, 263, 500, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 4, 12, 262, 500, 0, 0, 0, MODE_NONE, 0));
		// autumn night off, autumn day heat
		steps.push_back(mk_row(1, 10, 0, 100, 500, 1, -400, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 11, 18, 241, 500, 0, 0, 0, MODE_NONE, 0));
		// summer: too cold, dry, dry held, released, cool at night, cool held
		steps.push_back(mk_row(1, 6, 12, 200, 1000, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 7, 12, 250, 621, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 8, 12, 263, 700, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 9, 12, 263, 620, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 9, 3, 300, 0, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 6, 12, 263, 0, 0, 0, 0, MODE_NONE, 0));
		// winter day warm enough, then humidity at its raw maximum
		steps.push_back(mk_row(1, 13, 12, 300, 500, 0, 0, 0, MODE_NONE, 0));
		steps.push_back(mk_row(1, 14, 12, -1, 1023, 1, 600, 0, MODE_NONE, 0));
		steps.push_back(mk_row(0, 6, 12, 300, 1000, 0, 0, 0, MODE_NONE, 0));

		// reset values written back explicitly so every register sees a write
		apply_settings(242, 265, 3, 620, 0);
		foreach (steps[i])
			offer_sample(steps[i].smp, steps[i].typed, steps[i].beat);
		wait_all_results();

		for (int p = 0; p < RandPhases; p++) begin
			case (p)
				0: apply_settings(-400, 850, 0, 0, -400);
				1: apply_settings(850, -400, 100, 1000, 400);
				2: apply_settings(200, 260, 100, 500, 50);
				3: apply_settings(242, 265, 3, 620, 0);
				default: begin
					// mostly sane thresholds, sometimes any raw pattern
					if ($urandom_range(0, 99) < 70) begin
						lo = int'($urandom_range(0, 500)) - 100;
						hi = lo + int'($urandom_range(0, 60));
						apply_settings(lo, hi, $urandom_range(0, 20), $urandom_range(300, 900),
							int'($urandom_range(0, 100)) - 50);
					end else begin
						apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
					end
				end
			endcase
			// one phase runs with no idling on either side
			idle_on = (p != 3);
			for (int i = 0; i < PhaseBeats; i++) begin
				if (p == 2 && i == 40) begin
					// sender pauses for a full drain, then the result side holds off
					// while samples keep coming so the pipe fills and stalls its input
					wait_all_results();
					idle_on   = 1'b0;
					hold_long = 1'b1;
				end
				if (p == 2 && i == 75)
					idle_on = 1'b1;
				offer_sample(random_sample(), 1'b0, no_beat);
			end
			wait_all_results();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/scms_pkg.sv
hw/rtl/scms_in_if.sv
hw/rtl/scms_out_if.sv
hw/rtl/scms_cfg.sv
hw/rtl/scms_decide.sv
hw/rtl/seasonal_climate_mode_selector.sv
tb/tb_seasonal_climate_mode_selector.sv
